>>> design/ccs_pkg.sv
// Package for the C comment stripper: character codes, payload types and
// result queue sizing. No dependencies; used by the top level and the testbench.
`default_nettype none

package ccs_pkg;

   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   // result queue: two slots per request plus slack for one-per-cycle flow
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last;
   } rsp_type;

endpackage

`default_nettype wire

>>> design/ccs_if.sv
// Valid/ready channel interfaces for the C comment stripper.
// Does not depend on ccs_pkg; field widths match the ccs_pkg payload types.
`default_nettype none

interface ccs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface ccs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       last;

   modport source (output valid, output out_byte, output byte_valid, output last,
                   input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input last,
                   output ready);
endinterface

`default_nettype wire

>>> design/c_comment_stripper_top.sv
// C comment stripper top level: input register, per-byte decode, result queue.
// Depends on ccs_pkg and the ccs_req_if / ccs_rsp_if interfaces.
//
//   channel  | dir | payload                          | handshake
//   req_ch   | in  | in_byte[7:0], end_of_input       | valid/ready
//   rsp_ch   | out | out_byte[7:0], byte_valid, last  | valid/ready
//
// A request is registered, then decoded combinationally against the comment mode
// and held-marker registers, producing zero, one or two results into a
// four-entry queue whose head is presented on rsp_ch.
// One request per cycle is sustained while rsp_ch is ready and each request yields
// at most one result; a request that yields two results adds two queue entries.
// Reset (synchronous) clears mode, held marker, input valid and the queue.
// rsp_ch stalls back up through the queue; decode waits for two free slots.
`default_nettype none

module c_comment_stripper_top (
   input  wire            clock,
   input  wire            reset,
   ccs_req_if.sink        req_ch,
   ccs_rsp_if.source      rsp_ch
);

   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_LINE  = 2'd1,
      MODE_BLOCK = 2'd2
   } mode_type;

   localparam int unsigned AW = ccs_pkg::QUEUE_AW;

   // input register
   logic              in_valid_ff;
   ccs_pkg::req_type  in_ff;

   // stripper state
   mode_type          mode_ff, mode_in;
   logic              held_ff, held_in;

   // result queue
   ccs_pkg::rsp_type  queue_ff [ccs_pkg::QUEUE_DEPTH];
   logic [AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]       count_ff;

   ccs_pkg::rsp_type  res0, res1;
   logic [1:0]        push_n;
   logic              advance;
   logic              pop;
   logic [AW-1:0]     wr_ptr_next;

   assign advance = in_valid_ff &&
                    (count_ff <= (AW+1)'(ccs_pkg::QUEUE_DEPTH - 2));
   assign pop     = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = !in_valid_ff || advance;

   assign wr_ptr_next = wr_ptr_ff + AW'(1);

   always_comb begin
      mode_in = mode_ff;
      held_in = held_ff;
      push_n  = 2'd0;
      res0    = '{out_byte: 8'h00, byte_valid: 1'b0, last: 1'b0};
      res1    = '{out_byte: 8'h00, byte_valid: 1'b0, last: 1'b0};
      if (in_ff.end_of_input) begin
         push_n = 2'd1;
         // flush a held slash outside comments
         if (held_ff && (mode_ff != MODE_LINE) && (mode_ff != MODE_BLOCK)) begin
            res0 = '{out_byte: ccs_pkg::CH_SLASH, byte_valid: 1'b1, last: 1'b1};
         end else begin
            res0 = '{out_byte: 8'h00, byte_valid: 1'b0, last: 1'b1};
         end
         mode_in = MODE_NONE;
         held_in = 1'b0;
      end else begin
         unique case (mode_ff)
            MODE_LINE: begin
               if (in_ff.in_byte == ccs_pkg::CH_NEWLINE) begin
                  push_n  = 2'd1;
                  res0    = '{out_byte: ccs_pkg::CH_NEWLINE, byte_valid: 1'b1,
                              last: 1'b0};
                  mode_in = MODE_NONE;
               end
               held_in = 1'b0;
            end
            MODE_BLOCK: begin
               if (held_ff && in_ff.in_byte == ccs_pkg::CH_SLASH) begin
                  mode_in = MODE_NONE;
                  held_in = 1'b0;
               end else begin
                  if (in_ff.in_byte == ccs_pkg::CH_NEWLINE) begin
                     push_n = 2'd1;
                     res0   = '{out_byte: ccs_pkg::CH_NEWLINE, byte_valid: 1'b1,
                                last: 1'b0};
                  end
                  held_in = (in_ff.in_byte == ccs_pkg::CH_STAR);
               end
            end
            default: begin
               // outside comments; the unused mode code behaves the same
               mode_in = MODE_NONE;
               held_in = 1'b0;
               if (held_ff) begin
                  push_n = 2'd1;
                  if (in_ff.in_byte == ccs_pkg::CH_SLASH) begin
                     res0    = '{out_byte: ccs_pkg::CH_SPACE, byte_valid: 1'b1,
                                 last: 1'b0};
                     mode_in = MODE_LINE;
                  end else if (in_ff.in_byte == ccs_pkg::CH_STAR) begin
                     res0    = '{out_byte: ccs_pkg::CH_SPACE, byte_valid: 1'b1,
                                 last: 1'b0};
                     mode_in = MODE_BLOCK;
                  end else begin
                     // release the held slash, then the byte itself
                     push_n = 2'd2;
                     res0   = '{out_byte: ccs_pkg::CH_SLASH, byte_valid: 1'b1,
                                last: 1'b0};
                     res1   = '{out_byte: in_ff.in_byte, byte_valid: 1'b1,
                                last: 1'b0};
                  end
               end else if (in_ff.in_byte == ccs_pkg::CH_SLASH) begin
                  held_in = 1'b1;
               end else begin
                  push_n = 2'd1;
                  res0   = '{out_byte: in_ff.in_byte, byte_valid: 1'b1, last: 1'b0};
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_NONE;
         held_ff     <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            mode_ff   <= mode_in;
            held_ff   <= held_in;
            wr_ptr_ff <= wr_ptr_ff + AW'(push_n);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + AW'(1);
         end
         count_ff <= count_ff + (advance ? (AW+1)'(push_n) : '0)
                     - (pop ? (AW+1)'(1) : '0);
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_ff.in_byte      <= req_ch.in_byte;
         in_ff.end_of_input <= req_ch.end_of_input;
      end
      if (advance && push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (advance && push_n == 2'd2) begin
         queue_ff[wr_ptr_next] <= res1;
      end
   end

   assign rsp_ch.valid      = (count_ff != '0);
   assign rsp_ch.out_byte   = queue_ff[rd_ptr_ff].out_byte;
   assign rsp_ch.byte_valid = queue_ff[rd_ptr_ff].byte_valid;
   assign rsp_ch.last       = queue_ff[rd_ptr_ff].last;

endmodule

`default_nettype wire

>>> test/ccs_scoreboard_pkg.sv
// Scoreboard for the C comment stripper testbench: tracks comment state per
// request and queues the expected results. Depends on ccs_pkg for the types.
`default_nettype none

package ccs_scoreboard_pkg;

   typedef enum logic [1:0] {
      STRIP_TEXT  = 2'd0,
      STRIP_LINE  = 2'd1,
      STRIP_BLOCK = 2'd2
   } strip_mode_type;

   localparam int unsigned REPORT_LIMIT = 10;

   class strip_scoreboard_type;
      strip_mode_type   mode;
      bit               held;
      ccs_pkg::rsp_type expected_q[$];
      int unsigned      requests;
      int unsigned      streams;
      int unsigned      line_comments;
      int unsigned      block_comments;
      int unsigned      checked;
      int unsigned      mismatches;

      function new();
         mode = STRIP_TEXT;
         held = 1'b0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void push_result(logic [7:0] b, logic v, logic l);
         ccs_pkg::rsp_type r;
         r.out_byte   = b;
         r.byte_valid = v;
         r.last       = l;
         expected_q.push_back(r);
      endfunction

      // Predict the results of one accepted request and advance the comment state.
      function void note_request(logic [7:0] b, logic eoi);
         requests++;
         if (eoi) begin
            if (mode == STRIP_TEXT && held) begin
               push_result(ccs_pkg::CH_SLASH, 1'b1, 1'b1);
            end else begin
               push_result(8'h00, 1'b0, 1'b1);
            end
            mode = STRIP_TEXT;
            held = 1'b0;
            streams++;
            return;
         end
         case (mode)
            STRIP_LINE: begin
               if (b == ccs_pkg::CH_NEWLINE) begin
                  push_result(ccs_pkg::CH_NEWLINE, 1'b1, 1'b0);
                  mode = STRIP_TEXT;
               end
               held = 1'b0;
            end
            STRIP_BLOCK: begin
               if (held && b == ccs_pkg::CH_SLASH) begin
                  mode = STRIP_TEXT;
                  held = 1'b0;
               end else begin
                  if (b == ccs_pkg::CH_NEWLINE) push_result(ccs_pkg::CH_NEWLINE, 1'b1, 1'b0);
                  held = (b == ccs_pkg::CH_STAR);
               end
            end
            default: begin
               if (held) begin
                  if (b == ccs_pkg::CH_SLASH) begin
                     push_result(ccs_pkg::CH_SPACE, 1'b1, 1'b0);
                     mode = STRIP_LINE;
                     line_comments++;
                  end else if (b == ccs_pkg::CH_STAR) begin
                     // the opening star does not count toward a closing pair
                     push_result(ccs_pkg::CH_SPACE, 1'b1, 1'b0);
                     mode = STRIP_BLOCK;
                     block_comments++;
                  end else begin
                     push_result(ccs_pkg::CH_SLASH, 1'b1, 1'b0);
                     push_result(b, 1'b1, 1'b0);
                     mode = STRIP_TEXT;
                  end
                  held = 1'b0;
               end else if (b == ccs_pkg::CH_SLASH) begin
                  held = 1'b1;
                  mode = STRIP_TEXT;
               end else begin
                  push_result(b, 1'b1, 1'b0);
                  mode = STRIP_TEXT;
               end
            end
         endcase
      endfunction

      function void check_response(logic [7:0] b, logic v, logic l);
         ccs_pkg::rsp_type want;
         checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR: unexpected result out_byte=%02h byte_valid=%0b last=%0b",
                        b, v, l);
            return;
         end
         want = expected_q.pop_front();
         if (want.out_byte !== b || want.byte_valid !== v || want.last !== l) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR: result %0d (byte/valid/last) expected %02h/%0b/%0b, got %02h/%0b/%0b",
                        checked, want.out_byte, want.byte_valid, want.last, b, v, l);
         end
      endfunction
   endclass

endpackage

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for c_comment_stripper_top: directed comment cases,
// then random source text under varied idle/stall phases. Depends on ccs_pkg,
// the channel interfaces and ccs_scoreboard_pkg.
`default_nettype none

module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 8;
   localparam int RESET_CYCLES = 12;
   localparam int TOTAL_ITEMS  = 1350;
   localparam int END_SLACK    = 8;
   localparam int CYCLE_LIMIT  = 300000;

   logic clock = 1'b0;
   logic reset;

   ccs_req_if req_ch ();
   ccs_rsp_if rsp_ch ();

   c_comment_stripper_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ccs_scoreboard_pkg::strip_scoreboard_type sb = new();

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned sent_count    = 0;
   int unsigned cycle_count   = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, sb.pending());
         $display("c_comment_stripper_top regression: fail");
         $finish;
      end
   end

   // receiver: random backpressure, changed on the falling edge
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response(rsp_ch.out_byte, rsp_ch.byte_valid, rsp_ch.last);
   end

   // Enter and leave at a falling edge; hold valid across back-to-back requests.
   task automatic send_request(input logic [7:0] b, input logic eoi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.in_byte      <= b;
      req_ch.end_of_input <= eoi;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(b, eoi);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (END_SLACK) @(negedge clock);
   endtask

   // Comment body or plain text: biased toward the characters that matter.
   function automatic logic [7:0] body_byte();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 40) return 8'($urandom_range(255));
      else if (pick < 60) return ccs_pkg::CH_STAR;
      else if (pick < 75) return ccs_pkg::CH_SLASH;
      else if (pick < 90) return ccs_pkg::CH_NEWLINE;
      else return ccs_pkg::CH_SPACE;
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(2))
         0:       return ccs_pkg::CH_SLASH;
         1:       return ccs_pkg::CH_STAR;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_fragment();
      int unsigned pick;
      int unsigned len;
      pick = $urandom_range(99);
      len  = $urandom_range(10);
      if (pick < 30) begin
         send_request(ccs_pkg::CH_SLASH, 1'b0);
         send_request(ccs_pkg::CH_SLASH, 1'b0);
         repeat (len) send_request(body_byte(), 1'b0);
         send_request(ccs_pkg::CH_NEWLINE, 1'b0);
      end else if (pick < 62) begin
         send_request(ccs_pkg::CH_SLASH, 1'b0);
         send_request(ccs_pkg::CH_STAR, 1'b0);
         repeat (len) send_request(body_byte(), 1'b0);
         repeat ($urandom_range(1, 3)) send_request(ccs_pkg::CH_STAR, 1'b0);
         send_request(ccs_pkg::CH_SLASH, 1'b0);
      end else if (pick < 90) begin
         repeat (len + 1) send_request(body_byte(), 1'b0);
      end else if (pick < 96) begin
         repeat (len + 1) send_request(noise_byte(), 1'b0);
      end else begin
         // broken tail: sometimes cut a comment off mid-way, then end the stream
         if (pick < 98) begin
            send_request(ccs_pkg::CH_SLASH, 1'b0);
            send_request(($urandom_range(1) != 0) ? ccs_pkg::CH_STAR : ccs_pkg::CH_SLASH,
                         1'b0);
            repeat (len) send_request(body_byte(), 1'b0);
         end
         send_request(8'($urandom_range(255)), 1'b1);
      end
   endtask

   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                            input int unsigned items);
      int unsigned target;
      target        = sent_count + items;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      while (sent_count < target) send_fragment();
      wait_for_drain();
   endtask

   initial begin
      int unsigned phase_items;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.in_byte      = 8'h00;
      req_ch.end_of_input = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes of the byte, including the zero byte as plain text
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      // held slash followed by another byte
      send_request(ccs_pkg::CH_SLASH, 1'b0);
      send_request(8'h78, 1'b0);
      // line comment: a star inside is ignored, the newline is kept
      send_request(ccs_pkg::CH_SLASH, 1'b0);
      send_request(ccs_pkg::CH_SLASH, 1'b0);
      send_request(ccs_pkg::CH_STAR, 1'b0);
      send_request(ccs_pkg::CH_NEWLINE, 1'b0);
      // block comment: opening star not reused, newline kept, star run closes
      send_request(ccs_pkg::CH_SLASH, 1'b0);
      send_request(ccs_pkg::CH_STAR, 1'b0);
      send_request(ccs_pkg::CH_SLASH, 1'b0);
      send_request(ccs_pkg::CH_NEWLINE, 1'b0);
      send_request(ccs_pkg::CH_STAR, 1'b0);
      send_request(ccs_pkg::CH_STAR, 1'b0);
      send_request(ccs_pkg::CH_SLASH, 1'b0);
      // end of stream with nothing held
      send_request(8'hA5, 1'b1);
      // end of stream flushes a held slash
      send_request(ccs_pkg::CH_SLASH, 1'b0);
      send_request(8'h5A, 1'b1);
      // unterminated block comment, then unterminated line comment
      send_request(ccs_pkg::CH_SLASH, 1'b0);
      send_request(ccs_pkg::CH_STAR, 1'b0);
      send_request(8'h00, 1'b1);
      send_request(ccs_pkg::CH_SLASH, 1'b0);
      send_request(ccs_pkg::CH_SLASH, 1'b0);
      send_request(8'hFF, 1'b1);
      wait_for_drain();

      phase_items = (TOTAL_ITEMS - sent_count) / 4;
      run_phase(0, 0, phase_items);
      run_phase(48, 0, phase_items);
      run_phase(0, 48, phase_items);
      run_phase(37, 37, phase_items);
      send_request(8'($urandom_range(255)), 1'b1);
      wait_for_drain();

      $display("Sent %0d requests in %0d streams; %0d line and %0d block comments opened.",
               sb.requests, sb.streams, sb.line_comments, sb.block_comments);
      $display("Checked %0d results across idle and backpressure phases, %0d mismatches.",
               sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("c_comment_stripper_top regression: pass");
      end else begin
         $display("c_comment_stripper_top regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
design/ccs_pkg.sv
design/ccs_if.sv
design/c_comment_stripper_top.sv
test/ccs_scoreboard_pkg.sv
test/tb_top.sv
